// ===== design/lattice_gas_exchange_step_core_defines.svh =====
// ----------------------------------------------------------------------------
// Lattice gas exchange step core: assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef LATTICE_GAS_EXCHANGE_STEP_CORE_DEFINES_SVH
`define LATTICE_GAS_EXCHANGE_STEP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LGES_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lattice gas core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LGES_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lattice gas core: next-cycle check failed");

`endif

// ===== design/lges_pkg.sv =====
// ----------------------------------------------------------------------------
// Lattice gas exchange step package
// Shared codes, types and constants of the lattice gas exchange core.
// ----------------------------------------------------------------------------
`default_nettype none

package lges_pkg;

  localparam int unsigned ROWS_DEF = 128;
  localparam int unsigned COLS_DEF = 128;

  // Columns counted per cycle by the shared population count unit while it is enabled.
  localparam int unsigned CHUNK = 8;

  localparam int unsigned CNT_W = 15;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_MOVE    = 2'd0,
    ACT_SNAP    = 2'd1,
    ACT_MEASURE = 2'd2,
    ACT_LOAD    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_STAY  = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_MV_RD,
    ST_MV_CHK,
    ST_MV_NB,
    ST_MV_WR0,
    ST_MV_WR1,
    ST_CP_RD,
    ST_CP_WR,
    ST_MS_RD,
    ST_MS_LD,
    ST_MS_CNT,
    ST_LOAD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clear;
    logic en;
  } cnt_ctrl_t;

endpackage

`default_nettype wire

// ===== design/lattice_gas_exchange_step_core.sv =====
// ----------------------------------------------------------------------------
// Lattice gas exchange step core
// Toroidal bit lattice with a snapshot copy; moves, snapshots, measures and
// reloads under a small sequencer around two row memories and one counter.
// ----------------------------------------------------------------------------
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid_i, in_ready_o, action_i, row_i, col_i, | in
//          | direction_i                                     |
//  output  | out_valid_o, out_ready_i, site_occupied_o,      | out
//          | overlap_count_o, particle_total_o               |
//
// A move reads the site row and, when it goes up or down, the neighbor row,
// then writes back the rows it read; it ends without a write when the site
// lies outside the lattice or is empty, or the direction is stay. A snapshot
// copies the lattice row by row, a load rewrites the checkerboard and clears
// the snapshot, and a measure sums eight columns at a time in the population
// count unit. After reset the core writes the checkerboard before it raises
// in_ready_o. One transaction is in work at a time; a finished result waits
// in the output register and the next transaction may be taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_gas_exchange_step_core #(
  parameter int unsigned ROWS = lges_pkg::ROWS_DEF,
  parameter int unsigned COLS = lges_pkg::COLS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 action_i,
  input  wire logic [6:0]                 row_i,
  input  wire logic [6:0]                 col_i,
  input  wire logic [1:0]                 direction_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            site_occupied_o,
  output logic [lges_pkg::CNT_W-1:0]      overlap_count_o,
  output logic [lges_pkg::CNT_W-1:0]      particle_total_o
);

  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CLW   = $clog2(COLS);
  localparam int unsigned CHUNK = lges_pkg::CHUNK;
  localparam int unsigned NCH   = (COLS + CHUNK - 1) / CHUNK;
  localparam int unsigned CHW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned SRW   = NCH * CHUNK;
  localparam int unsigned CW    = lges_pkg::CNT_W;

  lges_pkg::state_e  state_q, state_d;
  lges_pkg::action_e action_q, action_d;
  lges_pkg::dir_e    dir_q, dir_d;
  logic [6:0]        row_q, row_d;
  logic [6:0]        col_q, col_d;
  logic [RW-1:0]     row_cnt_q, row_cnt_d;
  logic [CHW-1:0]    ch_cnt_q, ch_cnt_d;
  logic [COLS-1:0]   buf0_q, buf0_d;
  logic [COLS-1:0]   buf1_q, buf1_d;
  logic [SRW-1:0]    lat_sr_q, lat_sr_d;
  logic [SRW-1:0]    snp_sr_q, snp_sr_d;
  logic              occ_q, occ_d;
  logic              out_valid_q, out_valid_d;
  logic              out_occ_q, out_occ_d;
  logic [CW-1:0]     out_ovl_q, out_ovl_d;
  logic [CW-1:0]     out_tot_q, out_tot_d;

  logic            lat_we, lat_re, snp_we, snp_re;
  logic [RW-1:0]   lat_waddr, lat_raddr;
  logic [COLS-1:0] lat_wdata, snp_wdata, lat_rdata, snp_rdata;

  lges_pkg::cnt_ctrl_t cnt_ctrl;
  logic [CW-1:0]       cnt_overlap, cnt_total;

  logic            in_range;
  logic [RW-1:0]   site_row, nbr_row, row_up, row_down;
  logic [CLW-1:0]  site_col, nbr_col;
  logic [COLS-1:0] cb_even, cb_row;
  logic [COLS-1:0] wr_right, wr_vert0, wr_vert1;
  logic            last_row, last_chunk;

  for (genvar gc = 0; gc < COLS; gc++) begin : g_cb
    assign cb_even[gc] = ((gc % 2) == 0);
  end

  assign cb_row = row_cnt_q[0] ? ~cb_even : cb_even;

  assign in_range = (32'(row_q) < ROWS) && (32'(col_q) < COLS);
  assign site_row = RW'(row_q);
  assign site_col = CLW'(col_q);
  assign nbr_col  = (site_col == CLW'(COLS - 1)) ? '0 : site_col + CLW'(1);
  assign row_up   = (site_row == '0) ? RW'(ROWS - 1) : site_row - RW'(1);
  assign row_down = (site_row == RW'(ROWS - 1)) ? '0 : site_row + RW'(1);
  assign nbr_row  = (dir_q == lges_pkg::DIR_UP) ? row_up : row_down;

  assign last_row   = (row_cnt_q == RW'(ROWS - 1));
  assign last_chunk = (ch_cnt_q == CHW'(NCH - 1));

  always_comb begin
    wr_right           = buf0_q;
    wr_right[site_col] = buf0_q[nbr_col];
    wr_right[nbr_col]  = 1'b1;
    wr_vert0           = buf0_q;
    wr_vert0[site_col] = buf1_q[site_col];
    wr_vert1           = buf1_q;
    wr_vert1[site_col] = 1'b1;
  end

  always_comb begin
    state_d     = state_q;
    action_d    = action_q;
    dir_d       = dir_q;
    row_d       = row_q;
    col_d       = col_q;
    row_cnt_d   = row_cnt_q;
    ch_cnt_d    = ch_cnt_q;
    buf0_d      = buf0_q;
    buf1_d      = buf1_q;
    lat_sr_d    = lat_sr_q;
    snp_sr_d    = snp_sr_q;
    occ_d       = occ_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_occ_d   = out_occ_q;
    out_ovl_d   = out_ovl_q;
    out_tot_d   = out_tot_q;
    in_ready_o  = 1'b0;
    lat_we      = 1'b0;
    lat_waddr   = row_cnt_q;
    lat_wdata   = cb_row;
    lat_re      = 1'b0;
    lat_raddr   = row_cnt_q;
    snp_we      = 1'b0;
    snp_wdata   = '0;
    snp_re      = 1'b0;
    cnt_ctrl    = '0;

    unique case (state_q)
      lges_pkg::ST_INIT, lges_pkg::ST_LOAD: begin
        lat_we = 1'b1;
        snp_we = 1'b1;
        if (last_row) begin
          row_cnt_d = '0;
          state_d   = (state_q == lges_pkg::ST_INIT) ? lges_pkg::ST_IDLE : lges_pkg::ST_DONE;
        end else begin
          row_cnt_d = row_cnt_q + RW'(1);
        end
      end
      lges_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          action_d  = lges_pkg::action_e'(action_i);
          dir_d     = lges_pkg::dir_e'(direction_i);
          row_d     = row_i;
          col_d     = col_i;
          occ_d     = 1'b0;
          row_cnt_d = '0;
          unique case (lges_pkg::action_e'(action_i))
            lges_pkg::ACT_MOVE:    state_d = lges_pkg::ST_MV_RD;
            lges_pkg::ACT_SNAP:    state_d = lges_pkg::ST_CP_RD;
            lges_pkg::ACT_MEASURE: begin
              cnt_ctrl.clear = 1'b1;
              state_d        = lges_pkg::ST_MS_RD;
            end
            lges_pkg::ACT_LOAD:    state_d = lges_pkg::ST_LOAD;
            default:               state_d = lges_pkg::ST_IDLE;
          endcase
        end
      end
      lges_pkg::ST_MV_RD: begin
        if (in_range) begin
          lat_re    = 1'b1;
          lat_raddr = site_row;
          state_d   = lges_pkg::ST_MV_CHK;
        end else begin
          state_d = lges_pkg::ST_DONE;
        end
      end
      lges_pkg::ST_MV_CHK: begin
        occ_d  = lat_rdata[site_col];
        buf0_d = lat_rdata;
        if (!lat_rdata[site_col] || dir_q == lges_pkg::DIR_STAY) begin
          state_d = lges_pkg::ST_DONE;
        end else if (dir_q == lges_pkg::DIR_RIGHT) begin
          state_d = lges_pkg::ST_MV_WR0;
        end else begin
          lat_re    = 1'b1;
          lat_raddr = nbr_row;
          state_d   = lges_pkg::ST_MV_NB;
        end
      end
      lges_pkg::ST_MV_NB: begin
        buf1_d  = lat_rdata;
        state_d = lges_pkg::ST_MV_WR0;
      end
      lges_pkg::ST_MV_WR0: begin
        lat_we    = 1'b1;
        lat_waddr = site_row;
        if (dir_q == lges_pkg::DIR_RIGHT) begin
          lat_wdata = wr_right;
          state_d   = lges_pkg::ST_DONE;
        end else begin
          lat_wdata = wr_vert0;
          state_d   = lges_pkg::ST_MV_WR1;
        end
      end
      lges_pkg::ST_MV_WR1: begin
        lat_we    = 1'b1;
        lat_waddr = nbr_row;
        lat_wdata = wr_vert1;
        state_d   = lges_pkg::ST_DONE;
      end
      lges_pkg::ST_CP_RD: begin
        lat_re  = 1'b1;
        state_d = lges_pkg::ST_CP_WR;
      end
      lges_pkg::ST_CP_WR: begin
        snp_we    = 1'b1;
        snp_wdata = lat_rdata;
        if (last_row) begin
          row_cnt_d = '0;
          state_d   = lges_pkg::ST_DONE;
        end else begin
          row_cnt_d = row_cnt_q + RW'(1);
          state_d   = lges_pkg::ST_CP_RD;
        end
      end
      lges_pkg::ST_MS_RD: begin
        lat_re  = 1'b1;
        snp_re  = 1'b1;
        state_d = lges_pkg::ST_MS_LD;
      end
      lges_pkg::ST_MS_LD: begin
        lat_sr_d = SRW'(lat_rdata);
        snp_sr_d = SRW'(snp_rdata);
        ch_cnt_d = '0;
        state_d  = lges_pkg::ST_MS_CNT;
      end
      lges_pkg::ST_MS_CNT: begin
        cnt_ctrl.en = 1'b1;
        lat_sr_d    = lat_sr_q >> CHUNK;
        snp_sr_d    = snp_sr_q >> CHUNK;
        if (!last_chunk) begin
          ch_cnt_d = ch_cnt_q + CHW'(1);
        end else if (last_row) begin
          row_cnt_d = '0;
          state_d   = lges_pkg::ST_DONE;
        end else begin
          row_cnt_d = row_cnt_q + RW'(1);
          state_d   = lges_pkg::ST_MS_RD;
        end
      end
      lges_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_occ_d   = occ_q;
          if (action_q == lges_pkg::ACT_MEASURE) begin
            out_ovl_d = cnt_overlap;
            out_tot_d = cnt_total;
          end else begin
            out_ovl_d = '0;
            out_tot_d = '0;
          end
          state_d = lges_pkg::ST_IDLE;
        end
      end
      default: state_d = lges_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lges_pkg::ST_INIT;
      row_cnt_q   <= '0;
      ch_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_cnt_q   <= row_cnt_d;
      ch_cnt_q    <= ch_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q  <= action_d;
    dir_q     <= dir_d;
    row_q     <= row_d;
    col_q     <= col_d;
    buf0_q    <= buf0_d;
    buf1_q    <= buf1_d;
    lat_sr_q  <= lat_sr_d;
    snp_sr_q  <= snp_sr_d;
    occ_q     <= occ_d;
    out_occ_q <= out_occ_d;
    out_ovl_q <= out_ovl_d;
    out_tot_q <= out_tot_d;
  end

  lges_row_mem #(
    .DEPTH (ROWS),
    .WIDTH (COLS)
  ) u_lattice_mem (
    .clk_i   (clk_i),
    .we_i    (lat_we),
    .waddr_i (lat_waddr),
    .wdata_i (lat_wdata),
    .re_i    (lat_re),
    .raddr_i (lat_raddr),
    .rdata_o (lat_rdata)
  );

  lges_row_mem #(
    .DEPTH (ROWS),
    .WIDTH (COLS)
  ) u_snapshot_mem (
    .clk_i   (clk_i),
    .we_i    (snp_we),
    .waddr_i (row_cnt_q),
    .wdata_i (snp_wdata),
    .re_i    (snp_re),
    .raddr_i (row_cnt_q),
    .rdata_o (snp_rdata)
  );

  lges_pop_unit u_pop_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (cnt_ctrl),
    .lat_chunk_i (lat_sr_q[CHUNK-1:0]),
    .snp_chunk_i (snp_sr_q[CHUNK-1:0]),
    .overlap_o   (cnt_overlap),
    .total_o     (cnt_total)
  );

  assign out_valid_o      = out_valid_q;
  assign site_occupied_o  = out_occ_q;
  assign overlap_count_o  = out_ovl_q;
  assign particle_total_o = out_tot_q;

endmodule

`default_nettype wire

// ===== design/lges_row_mem.sv =====
// ----------------------------------------------------------------------------
// Lattice gas row memory
// One row of sites per word, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lges_row_mem #(
  parameter int unsigned DEPTH = lges_pkg::ROWS_DEF,
  parameter int unsigned WIDTH = lges_pkg::COLS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/lges_pop_unit.sv =====
// ----------------------------------------------------------------------------
// Lattice gas population count unit
// Counts occupied and overlapping sites of one column chunk per cycle while
// enabled and accumulates both totals with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module lges_pop_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lges_pkg::cnt_ctrl_t          ctrl_i,
  input  wire logic [lges_pkg::CHUNK-1:0]   lat_chunk_i,
  input  wire logic [lges_pkg::CHUNK-1:0]   snp_chunk_i,
  output logic      [lges_pkg::CNT_W-1:0]   overlap_o,
  output logic      [lges_pkg::CNT_W-1:0]   total_o
);

  localparam int unsigned PCW = $clog2(lges_pkg::CHUNK + 1);
  localparam int unsigned CW  = lges_pkg::CNT_W;

  logic [CW-1:0] overlap_q, overlap_d;
  logic [CW-1:0] total_q, total_d;

  function automatic logic [PCW-1:0] popcount(input logic [lges_pkg::CHUNK-1:0] v);
    logic [PCW-1:0] n;
    n = '0;
    for (int i = 0; i < lges_pkg::CHUNK; i++) begin
      n = n + PCW'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] acc,
                                            input logic [PCW-1:0] inc);
    logic [CW:0] sum;
    sum = {1'b0, acc} + (CW+1)'(inc);
    if (sum > {1'b0, lges_pkg::COUNT_MAX}) begin
      return lges_pkg::COUNT_MAX;
    end
    return sum[CW-1:0];
  endfunction

  always_comb begin
    overlap_d = overlap_q;
    total_d   = total_q;
    if (ctrl_i.clear) begin
      overlap_d = '0;
      total_d   = '0;
    end else if (ctrl_i.en) begin
      overlap_d = sat_add(overlap_q, popcount(lat_chunk_i & snp_chunk_i));
      total_d   = sat_add(total_q, popcount(lat_chunk_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overlap_q <= '0;
      total_q   <= '0;
    end else begin
      overlap_q <= overlap_d;
      total_q   <= total_d;
    end
  end

  assign overlap_o = overlap_q;
  assign total_o   = total_q;

endmodule

`default_nettype wire

// ===== design/lges_port_checker.sv =====
// ----------------------------------------------------------------------------
// Lattice gas exchange step port checker
// Watches the ports of the core over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lattice_gas_exchange_step_core_defines.svh"

module lges_port_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic                       site_occupied_o,
  input wire logic [lges_pkg::CNT_W-1:0] overlap_count_o,
  input wire logic [lges_pkg::CNT_W-1:0] particle_total_o
);

  logic                         out_stall;
  logic [2*lges_pkg::CNT_W:0]   out_payload;
  logic                         counts_ordered;
  logic                         counts_zero;

  assign out_stall      = out_valid_o && !out_ready_i;
  assign out_payload    = {site_occupied_o, overlap_count_o, particle_total_o};
  assign counts_ordered = (overlap_count_o <= particle_total_o);
  assign counts_zero    = (overlap_count_o == '0) && (particle_total_o == '0);

  `LGES_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_payload))
  `LGES_ASSERT_NEXT(a_one_in_work, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `LGES_ASSERT_IMPL(a_overlap_bound, clk_i, rst_ni, out_valid_o, counts_ordered)
  `LGES_ASSERT_IMPL(a_move_no_count, clk_i, rst_ni, out_valid_o && site_occupied_o, counts_zero)

endmodule

bind lattice_gas_exchange_step_core lges_port_checker u_port_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .site_occupied_o  (site_occupied_o),
  .overlap_count_o  (overlap_count_o),
  .particle_total_o (particle_total_o)
);

`default_nettype wire

// ===== tb/sv/lattice_gas_exchange_step_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lattice gas exchange step core testbench
// Drives moves, snapshots, measures and checkerboard reloads through the
// valid/ready input channel. A behavioral copy of the lattice and snapshot
// predicts each result that a directed row does not fix, and each output
// transaction is compared field by field in order. A short directed table
// covers the wrap-around edges, the stay direction, blocked swaps and the
// reload. About nine hundred random transactions follow, with random idling on
// both sides, one long output stall and several pauses that drain the core.
// ----------------------------------------------------------------------------
module lattice_gas_exchange_step_core_tb;

  localparam int ROW_N = 128;
  localparam int COL_N = 128;
  localparam int CW = lges_pkg::CNT_W;
  localparam int RANDOM_ITEMS = 930;
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD = 400;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic          occupied;
    logic [CW-1:0] overlap;
    logic [CW-1:0] total;
  } result_t;

  typedef struct {
    lges_pkg::action_e act;
    logic [6:0]        row;
    logic [6:0]        col;
    lges_pkg::dir_e    dir;
    bit                fixed;
    result_t           res;
  } stim_row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  logic [1:0]    action_i;
  logic [6:0]    row_i;
  logic [6:0]    col_i;
  logic [1:0]    direction_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic          site_occupied_o;
  logic [CW-1:0] overlap_count_o;
  logic [CW-1:0] particle_total_o;

  bit [COL_N-1:0] lattice_bits [ROW_N];
  bit [COL_N-1:0] snap_bits [ROW_N];
  result_t        exp_results [$];

  int  n_move;
  int  n_occupied;
  int  n_snap;
  int  n_measure;
  int  n_load;
  int  n_checked;
  int  n_fail;
  int  idle_cycles;
  bit  long_hold_req;
  bit  free_run;

  stim_row_t directed_tbl [18] = '{
    '{lges_pkg::ACT_MEASURE, 7'd0,   7'd0,   lges_pkg::DIR_RIGHT, 1'b1, '{1'b0, 15'd0, 15'd8192}},
    '{lges_pkg::ACT_SNAP,    7'd0,   7'd0,   lges_pkg::DIR_RIGHT, 1'b1, '{1'b0, 15'd0, 15'd0}},
    '{lges_pkg::ACT_MEASURE, 7'd127, 7'd127, lges_pkg::DIR_DOWN,  1'b1,
      '{1'b0, 15'd8192, 15'd8192}},
    '{lges_pkg::ACT_MOVE,    7'd0,   7'd0,   lges_pkg::DIR_RIGHT, 1'b1, '{1'b1, 15'd0, 15'd0}},
    '{lges_pkg::ACT_MOVE,    7'd0,   7'd1,   lges_pkg::DIR_STAY,  1'b0, '0},
    '{lges_pkg::ACT_MOVE,    7'd0,   7'd1,   lges_pkg::DIR_DOWN,  1'b0, '0},
    '{lges_pkg::ACT_MOVE,    7'd127, 7'd127, lges_pkg::DIR_RIGHT, 1'b1, '{1'b1, 15'd0, 15'd0}},
    '{lges_pkg::ACT_MOVE,    7'd0,   7'd2,   lges_pkg::DIR_UP,    1'b1, '{1'b1, 15'd0, 15'd0}},
    '{lges_pkg::ACT_MOVE,    7'd127, 7'd3,   lges_pkg::DIR_DOWN,  1'b1, '{1'b1, 15'd0, 15'd0}},
    '{lges_pkg::ACT_MOVE,    7'd64,  7'd63,  lges_pkg::DIR_RIGHT, 1'b1, '{1'b0, 15'd0, 15'd0}},
    '{lges_pkg::ACT_MOVE,    7'd127, 7'd0,   lges_pkg::DIR_UP,    1'b0, '0},
    '{lges_pkg::ACT_MEASURE, 7'd85,  7'd42,  lges_pkg::DIR_STAY,  1'b0, '0},
    '{lges_pkg::ACT_LOAD,    7'd127, 7'd127, lges_pkg::DIR_DOWN,  1'b1, '{1'b0, 15'd0, 15'd0}},
    '{lges_pkg::ACT_MEASURE, 7'd0,   7'd0,   lges_pkg::DIR_RIGHT, 1'b1, '{1'b0, 15'd0, 15'd8192}},
    '{lges_pkg::ACT_MOVE,    7'd127, 7'd127, lges_pkg::DIR_DOWN,  1'b1, '{1'b1, 15'd0, 15'd0}},
    '{lges_pkg::ACT_MOVE,    7'd127, 7'd0,   lges_pkg::DIR_UP,    1'b1, '{1'b0, 15'd0, 15'd0}},
    '{lges_pkg::ACT_SNAP,    7'd42,  7'd85,  lges_pkg::DIR_UP,    1'b1, '{1'b0, 15'd0, 15'd0}},
    '{lges_pkg::ACT_MEASURE, 7'd0,   7'd0,   lges_pkg::DIR_RIGHT, 1'b0, '0}
  };

  lattice_gas_exchange_step_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .row_i            (row_i),
    .col_i            (col_i),
    .direction_i      (direction_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .site_occupied_o  (site_occupied_o),
    .overlap_count_o  (overlap_count_o),
    .particle_total_o (particle_total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void fill_checkerboard();
    for (int r = 0; r < ROW_N; r++) begin
      for (int c = 0; c < COL_N; c++) begin
        lattice_bits[r][c] = ((r + c) % 2 == 0);
      end
      snap_bits[r] = '0;
    end
  endfunction

  function automatic result_t lattice_apply(lges_pkg::action_e act, logic [6:0] row,
                                            logic [6:0] col, lges_pkg::dir_e dir);
    result_t res;
    int      nr;
    int      nc;
    int      both;
    int      total;
    bit      held;
    res = '0;
    nr = row;
    nc = col;
    both = 0;
    total = 0;
    case (act)
      lges_pkg::ACT_MOVE: begin
        if (row < ROW_N && col < COL_N && lattice_bits[row][col]) begin
          res.occupied = 1'b1;
          case (dir)
            lges_pkg::DIR_RIGHT: nc = (col == COL_N - 1) ? 0 : int'(col) + 1;
            lges_pkg::DIR_UP:    nr = (row == 0) ? ROW_N - 1 : int'(row) - 1;
            lges_pkg::DIR_DOWN:  nr = (row == ROW_N - 1) ? 0 : int'(row) + 1;
            default:             ;
          endcase
          held = lattice_bits[row][col];
          lattice_bits[row][col] = lattice_bits[nr][nc];
          lattice_bits[nr][nc] = held;
        end
      end
      lges_pkg::ACT_SNAP: begin
        for (int r = 0; r < ROW_N; r++) snap_bits[r] = lattice_bits[r];
      end
      lges_pkg::ACT_MEASURE: begin
        for (int r = 0; r < ROW_N; r++) begin
          total += $countones(lattice_bits[r]);
          both += $countones(lattice_bits[r] & snap_bits[r]);
        end
        res.overlap = (both > int'(lges_pkg::COUNT_MAX)) ? lges_pkg::COUNT_MAX
                                                          : CW'(both);
        res.total = (total > int'(lges_pkg::COUNT_MAX)) ? lges_pkg::COUNT_MAX
                                                         : CW'(total);
      end
      default: fill_checkerboard();
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [6:0] pick_index();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 7'd127 : 7'd0;
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic offer_item(lges_pkg::action_e act, logic [6:0] row, logic [6:0] col,
                            lges_pkg::dir_e dir, bit fixed, result_t res);
    result_t want;
    in_valid_i  <= 1'b1;
    action_i    <= act;
    row_i       <= row;
    col_i       <= col;
    direction_i <= dir;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    want = lattice_apply(act, row, col, dir);
    exp_results.push_back(fixed ? res : want);
    case (act)
      lges_pkg::ACT_MOVE: begin
        n_move++;
        if (want.occupied) n_occupied++;
      end
      lges_pkg::ACT_SNAP:    n_snap++;
      lges_pkg::ACT_MEASURE: n_measure++;
      default:               n_load++;
    endcase
  endtask

  task automatic sender_gap();
    int gap;
    gap = free_run ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (exp_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic compare_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_fail++;
    end
  endtask

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      begin : receiver_gap
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("lattice_gas_exchange_step_core verification failed");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (exp_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual occ=%0d ovl=%0d tot=%0d",
                   $time, site_occupied_o, overlap_count_o, particle_total_o);
          n_fail++;
        end else begin
          want = exp_results.pop_front();
          n_checked++;
          compare_field("site_occupied", CW'(want.occupied), CW'(site_occupied_o));
          compare_field("overlap_count", want.overlap, overlap_count_o);
          compare_field("particle_total", want.total, particle_total_o);
        end
      end
    end
  end

  initial begin : stimulus
    lges_pkg::action_e act;
    int                roll;
    in_valid_i    = 1'b0;
    action_i      = lges_pkg::ACT_MOVE;
    row_i         = '0;
    col_i         = '0;
    direction_i   = lges_pkg::DIR_RIGHT;
    rst_ni        = 1'b0;
    idle_cycles   = 0;
    long_hold_req = 1'b0;
    free_run      = 1'b0;
    fill_checkerboard();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tbl[i]) begin
      offer_item(directed_tbl[i].act, directed_tbl[i].row, directed_tbl[i].col,
                 directed_tbl[i].dir, directed_tbl[i].fixed, directed_tbl[i].res);
      sender_gap();
    end
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 200) long_hold_req = 1'b1;
      if (i == 400 || i == 750) drain_results();
      free_run = (i >= 500 && i < 620);
      roll = $urandom_range(0, 99);
      if (roll < 78) act = lges_pkg::ACT_MOVE;
      else if (roll < 87) act = lges_pkg::ACT_SNAP;
      else if (roll < 95) act = lges_pkg::ACT_MEASURE;
      else act = lges_pkg::ACT_LOAD;
      offer_item(act, pick_index(), pick_index(), lges_pkg::dir_e'($urandom_range(0, 3)),
                 1'b0, '0);
      sender_gap();
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d moves (%0d on occupied sites), %0d snapshots, %0d measures",
             n_move, n_occupied, n_snap, n_measure);
    $display("and %0d reloads; %0d results checked, %0d mismatches.", n_load, n_checked, n_fail);
    if (n_fail == 0) begin
      $display("lattice_gas_exchange_step_core verification clean");
    end else begin
      $display("lattice_gas_exchange_step_core verification failed");
    end
    $finish;
  end

endmodule
